FILE: rtl/core/scsam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package scsam_pkg;

	localparam int CHANNELS          = 6;
	localparam int SAMPLE_W          = 5;
	localparam int MIX_W             = 15;
	localparam int MASTER_W          = 8;
	localparam int CHAN_CFG_W        = 14;
	localparam int CFG_DATA_W        = 14;
	localparam int CFG_REGS          = CHANNELS + 2;
	localparam int CFG_IDX_W         = $clog2(CFG_REGS);
	localparam int STEP_W            = 5;
	localparam int STEPS             = 1 << STEP_W;
	localparam int LEVEL_W           = 4;
	localparam int VOL_W             = 5;
	localparam int GAIN_INT_W        = 8;
	localparam int GAIN_FRAC_DEFAULT = 16;
	localparam int GAIN_MAX_W        = 32;
	// 31 * 170.67 stays below 2^13, whatever the fraction width.
	localparam int TERM_W            = 13;
	localparam int SUM_W             = TERM_W + $clog2(CHANNELS);
	localparam int LFO_CHANNEL       = 1;

	// Register indexes on the configuration port.
	localparam int REG_MASTER = 0;
	localparam int REG_CHAN0  = 1;
	localparam int REG_LFO    = CHANNELS + 1;

	// Fields of a channel settings register.
	localparam int CH_EN_BIT  = 13;
	localparam int CH_VOL_LSB = 8;
	localparam int CH_L_LSB   = 4;
	localparam int CH_R_LSB   = 0;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_0;
		logic [SAMPLE_W-1:0] sample_1;
		logic [SAMPLE_W-1:0] sample_2;
		logic [SAMPLE_W-1:0] sample_3;
		logic [SAMPLE_W-1:0] sample_4;
		logic [SAMPLE_W-1:0] sample_5;
	} in_t;

	typedef struct packed {
		logic [MIX_W-1:0] left_mix;
		logic [MIX_W-1:0] right_mix;
	} out_t;

	typedef struct packed {
		logic [TERM_W-1:0] left;
		logic [TERM_W-1:0] right;
	} term_t;

	typedef logic [STEPS-1:0][GAIN_MAX_W-1:0] gain_table_t;

	// Level code to attenuation scale.
	function automatic logic [STEP_W-1:0] level_scale(input logic [LEVEL_W-1:0] code);
		logic [STEP_W-1:0] v;
		unique case (code)
			4'h0: v = 5'h00;
			4'h1: v = 5'h03;
			4'h2: v = 5'h05;
			4'h3: v = 5'h07;
			4'h4: v = 5'h09;
			4'h5: v = 5'h0b;
			4'h6: v = 5'h0d;
			4'h7: v = 5'h0f;
			4'h8: v = 5'h10;
			4'h9: v = 5'h13;
			4'ha: v = 5'h15;
			4'hb: v = 5'h17;
			4'hc: v = 5'h19;
			4'hd: v = 5'h1b;
			4'he: v = 5'h1d;
			4'hf: v = 5'h1f;
			default: v = 5'h00;
		endcase
		return v;
	endfunction

	// (a*b) >> 62 for Q62 operands; used only while elaborating the gain table.
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] ah, al, bh, bl, ll, m1, m2, t, low, high;
		ah   = a >> 32;
		al   = {32'h0, a[31:0]};
		bh   = b >> 32;
		bl   = {32'h0, b[31:0]};
		ll   = al * bl;
		m1   = ah * bl;
		m2   = al * bh;
		t    = (ll >> 32) + {32'h0, m1[31:0]} + {32'h0, m2[31:0]};
		low  = {t[31:0], ll[31:0]};
		high = ah * bh + (m1 >> 32) + (m2 >> 32) + (t >> 32);
		return (high << 2) | (low >> 62);
	endfunction

	function automatic logic [63:0] pow40_q62(input logic [63:0] x);
		logic [63:0] x2, x4, x8, x16, x32;
		x2  = mul_q62(x, x);
		x4  = mul_q62(x2, x2);
		x8  = mul_q62(x4, x4);
		x16 = mul_q62(x8, x8);
		x32 = mul_q62(x16, x16);
		return mul_q62(x32, x8);
	endfunction

	// Gain per attenuation step: 512/3 lowered by 1.5 dB per step, rounded,
	// with fbits fraction bits. The last step is silence.
	function automatic gain_table_t build_gain_table(input int fbits);
		gain_table_t tbl;
		logic [63:0] target, lo, hi, mid, p, q, g;
		target = (64'h1 << 62) / 64'd1000;
		lo     = 64'h0;
		hi     = 64'h1 << 62;
		p      = (64'h1 << 62) - 64'h1;
		tbl    = '0;
		for (int i = 0; i < 64; i++) begin
			if (hi - lo > 64'h1) begin
				mid = lo + ((hi - lo) >> 1);
				if (pow40_q62(mid) <= target) begin
					lo = mid;
				end else begin
					hi = mid;
				end
			end
		end
		for (int n = 0; n < STEPS - 1; n++) begin
			q      = p >> (40 - fbits);
			g      = (q + 64'd12288) / 64'd24576;
			tbl[n] = g[GAIN_MAX_W-1:0];
			p      = mul_q62(p, lo);
		end
		tbl[STEPS-1] = '0;
		return tbl;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/scsam_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// One channel: attenuation step, gain lookup and weighted sample, registered.
module scsam_lane #(
	parameter int GAIN_FRACTION_BITS = scsam_pkg::GAIN_FRAC_DEFAULT
) (
	input  wire logic                                 clk,
	input  wire logic [scsam_pkg::SAMPLE_W-1:0]       sample,
	input  wire logic [scsam_pkg::CHAN_CFG_W-1:0]     settings,
	input  wire logic [scsam_pkg::MASTER_W-1:0]       master,
	input  wire logic                                 mute,
	output scsam_pkg::term_t                          term_s1
);

	localparam int GAIN_W = scsam_pkg::GAIN_INT_W + GAIN_FRACTION_BITS;
	localparam int PROD_W = scsam_pkg::SAMPLE_W + GAIN_W;
	localparam scsam_pkg::gain_table_t GAIN_ROM =
		scsam_pkg::build_gain_table(GAIN_FRACTION_BITS);

	logic [scsam_pkg::VOL_W-1:0]  vol;
	logic [scsam_pkg::STEP_W-1:0] ml, mr, cl, cr;
	logic [6:0]                   sum_l, sum_r;
	logic [scsam_pkg::STEP_W-1:0] step_l, step_r;
	logic [GAIN_W-1:0]            gain_l, gain_r;
	logic [PROD_W-1:0]            prod_l, prod_r;
	logic                         active;

	assign vol = settings[scsam_pkg::CH_VOL_LSB +: scsam_pkg::VOL_W];
	assign ml  = scsam_pkg::level_scale(master[7:4]);
	assign mr  = scsam_pkg::level_scale(master[3:0]);
	assign cl  = scsam_pkg::level_scale(settings[scsam_pkg::CH_L_LSB +: scsam_pkg::LEVEL_W]);
	assign cr  = scsam_pkg::level_scale(settings[scsam_pkg::CH_R_LSB +: scsam_pkg::LEVEL_W]);

	assign active = settings[scsam_pkg::CH_EN_BIT] & ~mute;

	always_comb begin
		sum_l = (7'd31 - {2'b0, ml}) + (7'd31 - {2'b0, cl}) + (7'd31 - {2'b0, vol});
		sum_r = (7'd31 - {2'b0, mr}) + (7'd31 - {2'b0, cr}) + (7'd31 - {2'b0, vol});
		step_l = (sum_l > 7'd31) ? 5'd31 : sum_l[scsam_pkg::STEP_W-1:0];
		step_r = (sum_r > 7'd31) ? 5'd31 : sum_r[scsam_pkg::STEP_W-1:0];
		gain_l = GAIN_ROM[step_l][GAIN_W-1:0];
		gain_r = GAIN_ROM[step_r][GAIN_W-1:0];
		prod_l = {{GAIN_W{1'b0}}, sample} * {{scsam_pkg::SAMPLE_W{1'b0}}, gain_l};
		prod_r = {{GAIN_W{1'b0}}, sample} * {{scsam_pkg::SAMPLE_W{1'b0}}, gain_r};
	end

	always_ff @(posedge clk) begin
		if (active) begin
			term_s1.left  <= prod_l[GAIN_FRACTION_BITS +: scsam_pkg::TERM_W];
			term_s1.right <= prod_r[GAIN_FRACTION_BITS +: scsam_pkg::TERM_W];
		end else begin
			term_s1 <= '0;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/scsam_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// Adds the lane terms per side, saturates and registers the result beat.
module scsam_merge (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_s1,
	input  wire scsam_pkg::term_t terms_s1 [scsam_pkg::CHANNELS],
	output logic                  done,
	output scsam_pkg::out_t       result
);

	localparam logic [scsam_pkg::SUM_W-1:0] MIX_MAX = {scsam_pkg::MIX_W{1'b1}};

	logic [scsam_pkg::SUM_W-1:0] sum_l, sum_r;
	logic                        valid_s2;
	scsam_pkg::out_t             result_s2;

	always_comb begin
		sum_l = '0;
		sum_r = '0;
		for (int c = 0; c < scsam_pkg::CHANNELS; c++) begin
			sum_l = sum_l + scsam_pkg::SUM_W'(terms_s1[c].left);
			sum_r = sum_r + scsam_pkg::SUM_W'(terms_s1[c].right);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		result_s2.left_mix  <= (sum_l > MIX_MAX) ? MIX_MAX[scsam_pkg::MIX_W-1:0]
		                                         : sum_l[scsam_pkg::MIX_W-1:0];
		result_s2.right_mix <= (sum_r > MIX_MAX) ? MIX_MAX[scsam_pkg::MIX_W-1:0]
		                                         : sum_r[scsam_pkg::MIX_W-1:0];
	end

	assign done   = valid_s2;
	assign result = result_s2;

endmodule
`default_nettype wire

FILE: rtl/core/six_channel_stereo_attenuation_mixer.sv
`timescale 1ns / 1ps
`default_nettype none
// Six-channel stereo attenuation mixer.
//
// A beat on the input side is one sample per channel, offered on sample and
// taken at a rising edge where start is high and busy is low. Busy is always
// low: the block takes a new beat every cycle.
// Each accepted beat yields exactly one result beat on result, marked by done
// for exactly one cycle. The lane stage looks up every channel's gain and
// weights its sample in a lane of its own; the merge stage then adds the lane
// terms for each side and saturates. Throughput is one beat per cycle, since
// every lane has its own multiplier per side and neither of the two stages
// can stall.
// The receiver cannot stall the block, so results are never held back.
// Configuration goes through cfg_we, cfg_index and cfg_data: index 0 is the
// master level, indexes 1 to 6 are the channel settings, 7 is the LFO mode
// that mutes channel one. Writes take effect at once; they must be made while
// no beat is in flight, unenforced by the block; all eight indexes are in use.
// Asynchronous reset clears all configuration registers, which silences every
// channel, and drops any beat in flight.
module six_channel_stereo_attenuation_mixer #(
	parameter int GAIN_FRACTION_BITS = scsam_pkg::GAIN_FRAC_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire scsam_pkg::in_t                      sample,
	input  wire logic                                cfg_we,
	input  wire logic [scsam_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [scsam_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                                     done,
	output scsam_pkg::out_t                          result
);

	// Configuration registers.
	logic [scsam_pkg::MASTER_W-1:0]   master_q;
	logic [scsam_pkg::CHAN_CFG_W-1:0] chan_q [scsam_pkg::CHANNELS];
	logic                             lfo_q;

	logic [scsam_pkg::SAMPLE_W-1:0]   smp [scsam_pkg::CHANNELS];
	scsam_pkg::term_t                 terms_s1 [scsam_pkg::CHANNELS];
	logic                             valid_s1;

	assign busy = 1'b0;

	// Unpack the input beat into per-lane samples.
	assign smp[0] = sample.sample_0;
	assign smp[1] = sample.sample_1;
	assign smp[2] = sample.sample_2;
	assign smp[3] = sample.sample_3;
	assign smp[4] = sample.sample_4;
	assign smp[5] = sample.sample_5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q <= '0;
			lfo_q    <= 1'b0;
			for (int c = 0; c < scsam_pkg::CHANNELS; c++) begin
				chan_q[c] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == scsam_pkg::CFG_IDX_W'(scsam_pkg::REG_MASTER)) begin
				master_q <= cfg_data[scsam_pkg::MASTER_W-1:0];
			end
			if (cfg_index == scsam_pkg::CFG_IDX_W'(scsam_pkg::REG_LFO)) begin
				lfo_q <= cfg_data[0];
			end
			for (int c = 0; c < scsam_pkg::CHANNELS; c++) begin
				if (cfg_index == scsam_pkg::CFG_IDX_W'(scsam_pkg::REG_CHAN0 + c)) begin
					chan_q[c] <= cfg_data[scsam_pkg::CHAN_CFG_W-1:0];
				end
			end
		end
	end

	// Beat tracking through the lane stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	// One lane per channel; channel one is muted while the LFO mode is on.
	for (genvar c = 0; c < scsam_pkg::CHANNELS; c++) begin : g_lane
		logic mute;
		if (c == scsam_pkg::LFO_CHANNEL) begin : g_lfo
			assign mute = lfo_q;
		end else begin : g_plain
			assign mute = 1'b0;
		end
		scsam_lane #(
			.GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
		) u_lane (
			.clk      (clk),
			.sample   (smp[c]),
			.settings (chan_q[c]),
			.master   (master_q),
			.mute     (mute),
			.term_s1  (terms_s1[c])
		);
	end

	scsam_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.terms_s1 (terms_s1),
		.done     (done),
		.result   (result)
	);

endmodule
`default_nettype wire

FILE: verif/six_channel_stereo_attenuation_mixer_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the six-channel stereo attenuation mixer.
// Each input beat is scored as it is accepted, and the predicted mix is queued.
// A monitor compares every done beat against the oldest queued mix.
// Configuration is only rewritten once the pipeline has drained.
module six_channel_stereo_attenuation_mixer_test;
	import scsam_pkg::*;

	localparam int FRAC         = GAIN_FRAC_DEFAULT;
	localparam int QUIET_LIMIT  = 200;
	localparam int RANDOM_BEATS = 1250;
	localparam int MIX_CEILING  = (1 << MIX_W) - 1;

	// Attenuation scale for a 4-bit level code. Element 0 is the rightmost.
	localparam logic [15:0][STEP_W-1:0] LEVEL_STEP = {
		5'h1f, 5'h1d, 5'h1b, 5'h19, 5'h17, 5'h15, 5'h13, 5'h10,
		5'h0f, 5'h0d, 5'h0b, 5'h09, 5'h07, 5'h05, 5'h03, 5'h00
	};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	in_t                   sample    = '0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  done;
	out_t                  result;

	// This is the local copy of the mixer settings, as the block should hold them.
	logic [MASTER_W-1:0]   mix_master = '0;
	logic [CHAN_CFG_W-1:0] mix_chan [CHANNELS];
	logic                  mix_lfo    = 1'b0;

	// These are the raw words written to each register index in the next config pass.
	logic [CFG_DATA_W-1:0] reg_image [CFG_REGS];

	logic [GAIN_MAX_W-1:0] gain_by_step [STEPS];
	out_t                  pending_mix [$];
	out_t                  mix_want;
	int                    fail_count   = 0;
	int                    quiet_cycles = 0;
	int                    max_gap      = 0;

	six_channel_stereo_attenuation_mixer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sample    (sample),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	always #1 clk = ~clk;

	// This is the Q62 product. Both operands stay below 2^62, so bits 125:62 of
	// the full product hold the whole truncated result.
	function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] full;
		full = {64'h0, a} * {64'h0, b};
		return full[125:62];
	endfunction

	// x^40 is built as x^32 * x^8. The squarings truncate in the same order the
	// block's gain table expects.
	function automatic logic [63:0] q62_pow40(input logic [63:0] x);
		logic [63:0] x8, x32;
		x8 = x;
		repeat (3) x8 = q62_product(x8, x8);
		x32 = x8;
		repeat (2) x32 = q62_product(x32, x32);
		return q62_product(x32, x8);
	endfunction

	// The 1.5 dB ratio is the largest Q62 value r with r^40 <= 1/1000.
	// Each step's gain is 512/3 times r^n, rounded to FRAC fraction bits.
	// The last step is silence.
	task automatic build_gain_steps();
		logic [63:0] target, lo, hi, mid, p;
		target = (64'h1 << 62) / 64'd1000;
		lo     = 64'h0;
		hi     = 64'h1 << 62;
		p      = (64'h1 << 62) - 64'h1;
		while (hi - lo > 64'h1) begin
			mid = lo + ((hi - lo) >> 1);
			if (q62_pow40(mid) <= target) begin
				lo = mid;
			end else begin
				hi = mid;
			end
		end
		for (int n = 0; n < STEPS - 1; n++) begin
			gain_by_step[n] = GAIN_MAX_W'(((p >> (40 - FRAC)) + 64'd12288) / 64'd24576);
			p = q62_product(p, lo);
		end
		gain_by_step[STEPS-1] = '0;
	endtask

	// The three attenuations add up, and the total is clamped to the silent step.
	function automatic logic [STEP_W-1:0] total_steps(input logic [STEP_W-1:0] m,
			input logic [STEP_W-1:0] c, input logic [STEP_W-1:0] v);
		int s;
		s = 3 * (STEPS - 1) - int'(m) - int'(c) - int'(v);
		return (s > STEPS - 1) ? STEP_W'(STEPS - 1) : STEP_W'(s);
	endfunction

	function automatic out_t predict_mix(input in_t beat);
		logic [SAMPLE_W-1:0] smp [CHANNELS];
		logic [STEP_W-1:0]   ml, mr, cl, cr;
		logic [VOL_W-1:0]    vol;
		int                  left, right;
		out_t                mix;
		smp[0] = beat.sample_0;
		smp[1] = beat.sample_1;
		smp[2] = beat.sample_2;
		smp[3] = beat.sample_3;
		smp[4] = beat.sample_4;
		smp[5] = beat.sample_5;
		ml     = LEVEL_STEP[mix_master[7:4]];
		mr     = LEVEL_STEP[mix_master[3:0]];
		left   = 0;
		right  = 0;
		for (int c = 0; c < CHANNELS; c++) begin
			// A disabled channel adds nothing. Channel one is also silent in LFO mode.
			if (mix_chan[c][CH_EN_BIT] && !(c == LFO_CHANNEL && mix_lfo)) begin
				vol = mix_chan[c][CH_VOL_LSB +: VOL_W];
				cl  = LEVEL_STEP[mix_chan[c][CH_L_LSB +: LEVEL_W]];
				cr  = LEVEL_STEP[mix_chan[c][CH_R_LSB +: LEVEL_W]];
				left += int'((64'(smp[c]) *
					64'(gain_by_step[total_steps(ml, cl, vol)])) >> FRAC);
				right += int'((64'(smp[c]) *
					64'(gain_by_step[total_steps(mr, cr, vol)])) >> FRAC);
			end
		end
		mix.left_mix  = (left > MIX_CEILING) ? MIX_W'(MIX_CEILING) : MIX_W'(left);
		mix.right_mix = (right > MIX_CEILING) ? MIX_W'(MIX_CEILING) : MIX_W'(right);
		return mix;
	endfunction

	function automatic logic [CHAN_CFG_W-1:0] chan_word(input logic en,
			input logic [VOL_W-1:0] vol, input logic [LEVEL_W-1:0] l,
			input logic [LEVEL_W-1:0] r);
		logic [CHAN_CFG_W-1:0] w;
		w                         = '0;
		w[CH_EN_BIT]              = en;
		w[CH_VOL_LSB +: VOL_W]    = vol;
		w[CH_L_LSB +: LEVEL_W]    = l;
		w[CH_R_LSB +: LEVEL_W]    = r;
		return w;
	endfunction

	// Random level codes lean toward loud settings. Otherwise most steps would
	// saturate and the mix would sit at zero.
	function automatic logic [LEVEL_W-1:0] loudish_level();
		return ($urandom_range(0, 3) == 0) ? LEVEL_W'($urandom_range(0, 15))
			: LEVEL_W'($urandom_range(11, 15));
	endfunction

	function automatic logic [VOL_W-1:0] loudish_volume();
		return ($urandom_range(0, 3) == 0) ? VOL_W'($urandom_range(0, 31))
			: VOL_W'($urandom_range(22, 31));
	endfunction

	function automatic in_t random_beat();
		logic [$bits(in_t)-1:0] bits;
		case ($urandom_range(0, 7))
			0: bits = '1;
			1: bits = '0;
			default: bits = $bits(in_t)'($urandom);
		endcase
		return in_t'(bits);
	endfunction

	// This offers one input beat after a random gap and waits until it is taken.
	// Start stays high when the gap is zero, so beats can go back to back.
	task automatic send_beat(input in_t beat);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start  <= 1'b1;
		sample <= beat;
		do @(posedge clk); while (busy);
		pending_mix.push_back(predict_mix(beat));
	endtask

	// This stops offering beats and lets every queued mix come back.
	// It then idles on, so the pipeline is empty before the registers change.
	task automatic settle_pipeline();
		start <= 1'b0;
		while (pending_mix.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// This writes every register from reg_image, one per cycle. The local copy keeps
	// only the bits each register actually holds.
	task automatic program_regs();
		for (int i = 0; i < CFG_REGS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= reg_image[i];
			@(posedge clk);
		end
		cfg_we     <= 1'b0;
		mix_master = reg_image[REG_MASTER][MASTER_W-1:0];
		for (int c = 0; c < CHANNELS; c++) begin
			mix_chan[c] = reg_image[REG_CHAN0 + c][CHAN_CFG_W-1:0];
		end
		mix_lfo = reg_image[REG_LFO][0];
	endtask

	// After reset every channel is disabled, so full-scale samples must mix to zero.
	task automatic test_reset_silence();
		max_gap = 9;
		send_beat('1);
		send_beat(random_beat());
		settle_pipeline();
	endtask

	// Every level here is at maximum, so each channel gets the top gain.
	// The master word also carries stray high bits, which the block must drop.
	task automatic test_full_scale();
		reg_image[REG_MASTER] = '1;
		for (int c = 0; c < CHANNELS; c++) begin
			reg_image[REG_CHAN0 + c] = chan_word(1'b1, '1, '1, '1);
		end
		reg_image[REG_LFO] = '0;
		program_regs();
		max_gap = 0;
		send_beat('1);
		send_beat('0);
		send_beat(random_beat());
		settle_pipeline();
	endtask

	// LFO mode mutes channel one. The enable is written as a wide all-ones word,
	// and only bit zero should count.
	task automatic test_lfo_mute();
		reg_image[REG_LFO] = '1;
		program_regs();
		max_gap = 9;
		send_beat('1);
		send_beat(random_beat());
		settle_pipeline();
	endtask

	// The even channels are switched off with every other field left at full.
	// The LFO word here has bit zero clear, so channel one plays again.
	task automatic test_disabled_channels();
		for (int c = 0; c < CHANNELS; c++) begin
			reg_image[REG_CHAN0 + c] = chan_word(c % 2 == 1, '1, '1, '1);
		end
		reg_image[REG_LFO] = CFG_DATA_W'(2);
		program_regs();
		max_gap = 0;
		send_beat('1);
		send_beat(random_beat());
		settle_pipeline();
	endtask

	// The left side sweeps the volume through every value, which walks the
	// left attenuation across all 32 steps. The right side walks through all
	// the channel level codes and through the loudest master level codes.
	task automatic test_step_sweep();
		int idx;
		for (int k = 0; k < 6; k++) begin
			reg_image[REG_MASTER] = {6'h2a, 4'hf, LEVEL_W'(15 - k)};
			for (int c = 0; c < CHANNELS; c++) begin
				idx = k * CHANNELS + c;
				reg_image[REG_CHAN0 + c] = chan_word(1'b1,
					VOL_W'((idx > 31) ? 31 : idx), 4'hf, LEVEL_W'(idx % 16));
			end
			reg_image[REG_LFO] = '0;
			program_regs();
			max_gap = $urandom_range(0, 1) * 9;
			send_beat('1);
			send_beat(random_beat());
			settle_pipeline();
		end
	endtask

	// Each random phase programs a fresh setting and then streams a batch of beats.
	// Now and then a phase uses an extreme setting: all ones or all zeros.
	// About a quarter of the phases run with no idle gaps at all.
	task automatic test_random_mix();
		int sent, batch;
		sent = 0;
		while (sent < RANDOM_BEATS) begin
			case ($urandom_range(0, 9))
				0: for (int i = 0; i < CFG_REGS; i++) reg_image[i] = '1;
				1: for (int i = 0; i < CFG_REGS; i++) reg_image[i] = '0;
				default: begin
					reg_image[REG_MASTER] = {6'($urandom), loudish_level(), loudish_level()};
					for (int c = 0; c < CHANNELS; c++) begin
						reg_image[REG_CHAN0 + c] = chan_word($urandom_range(0, 4) != 0,
							loudish_volume(), loudish_level(), loudish_level());
					end
					reg_image[REG_LFO] = CFG_DATA_W'($urandom);
				end
			endcase
			program_regs();
			max_gap = ($urandom_range(0, 3) == 0) ? 0 : 9;
			batch   = $urandom_range(40, 80);
			repeat (batch) send_beat(random_beat());
			sent += batch;
			settle_pipeline();
		end
	endtask

	// Each done beat is checked against the oldest mix still waiting.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_mix.size() == 0) begin
				$error("unexpected result beat: left_mix %0d right_mix %0d",
					result.left_mix, result.right_mix);
				fail_count++;
			end else begin
				mix_want = pending_mix.pop_front();
				if (result.left_mix !== mix_want.left_mix) begin
					$error("left_mix: expected %0d, actual %0d",
						mix_want.left_mix, result.left_mix);
					fail_count++;
				end
				if (result.right_mix !== mix_want.right_mix) begin
					$error("right_mix: expected %0d, actual %0d",
						mix_want.right_mix, result.right_mix);
					fail_count++;
				end
			end
		end
	end

	// This watchdog catches a hung run. Any accepted beat on either side
	// resets its count.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("six_channel_stereo_attenuation_mixer: mismatch");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < CFG_REGS; i++) reg_image[i] = '0;
		for (int c = 0; c < CHANNELS; c++) mix_chan[c] = '0;
		build_gain_steps();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_silence();
		test_full_scale();
		test_lfo_mute();
		test_disabled_channels();
		test_step_sweep();
		test_random_mix();
		repeat (5) @(posedge clk);
		if (fail_count == 0 && pending_mix.size() == 0) begin
			$display("six_channel_stereo_attenuation_mixer: match");
		end else begin
			$display("six_channel_stereo_attenuation_mixer: mismatch");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/scsam_pkg.sv
rtl/core/scsam_lane.sv
rtl/core/scsam_merge.sv
rtl/core/six_channel_stereo_attenuation_mixer.sv
verif/six_channel_stereo_attenuation_mixer_test.sv
